FILE: sv/cnc_pkg.sv
`timescale 1ns / 1ps

package cnc_pkg;

  // default operand width
  localparam int unsigned CncWidth = 16;

  // smallest common divisor that counts
  localparam int unsigned MinShared = 2;

  // result of one gcd run
  typedef struct packed {
    logic done;
    logic share;
  } cnc_gcd_res_t;

endpackage

FILE: sv/cnc_if.sv
`timescale 1ns / 1ps

interface cnc_req_if #(
  parameter int unsigned WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] n_value;
  logic [WIDTH-1:0] range_low;
  logic [WIDTH-1:0] range_high;

  modport source (output valid, n_value, range_low, range_high, input ready);
  modport sink   (input valid, n_value, range_low, range_high, output ready);
endinterface

interface cnc_rsp_if #(
  parameter int unsigned WIDTH = 16
);
  logic           valid;
  logic           ready;
  logic [WIDTH:0] share_count;

  modport source (output valid, share_count, input ready);
  modport sink   (input valid, share_count, output ready);
endinterface

FILE: sv/cnc_gcd.sv
`timescale 1ns / 1ps

module cnc_gcd import cnc_pkg::*; #(
  parameter int unsigned WIDTH = CncWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output cnc_gcd_res_t       res_o
);

  logic             busy_q, busy_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  cnc_gcd_res_t     res_q, res_d;
  logic             fin;
  logic             share;

  // one binary gcd step: shift out a factor of two, or subtract the odd pair
  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    fin   = 1'b0;
    share = 1'b0;
    if (a_q == WIDTH'(1) || b_q == WIDTH'(1)) begin
      fin = 1'b1;
    end else if (b_q == '0) begin
      fin   = 1'b1;
      share = 1'b1;
    end else if (!a_q[0] && !b_q[0]) begin
      // both even: two divides both
      fin   = 1'b1;
      share = 1'b1;
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q == b_q) begin
      fin   = 1'b1;
      share = 1'b1;
    end else if (a_q > b_q) begin
      a_d = a_q - b_q;
    end else begin
      b_d = b_q - a_q;
    end
  end

  always_comb begin
    busy_d    = busy_q;
    res_d     = '0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && fin) begin
      busy_d      = 1'b0;
      res_d.done  = 1'b1;
      res_d.share = share;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      res_q  <= '0;
    end else begin
      busy_q <= busy_d;
      res_q  <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: sv/count_non_coprime_in_range.sv
`timescale 1ns / 1ps

// Channel   Port    Direction  Payload
// request   req_i   in         n_value, range_low, range_high
// result    rsp_o   out        share_count
//
// Each range value runs through a binary gcd that shifts out one factor of
// two or subtracts once per cycle; every subtraction is followed by a shift.
// For n below two or an empty range no gcd runs and the request passes
// straight to the finish step. Reset clears all control state. A new
// request is taken once the previous count has moved into the result
// register; the finish step then holds until that register is free, and a
// stalled result holds until taken.

module count_non_coprime_in_range import cnc_pkg::*; #(
  parameter int unsigned WIDTH = CncWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cnc_req_if.sink           req_i,
  cnc_rsp_if.source         rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWait,
    StFinish
  } state_e;

  state_e           state_q;
  logic [WIDTH-1:0] n_q;
  logic [WIDTH-1:0] idx_q;
  logic [WIDTH-1:0] hi_q;
  logic [WIDTH:0]   cnt_q;
  logic             start_q;
  logic             out_valid_q;
  logic [WIDTH:0]   out_cnt_q;
  cnc_gcd_res_t     gcd_res;
  logic             req_hs;
  logic             rsp_hs;
  logic             load_out;

  assign req_i.ready       = (state_q == StIdle);
  assign req_hs            = req_i.valid && req_i.ready;
  assign rsp_hs            = rsp_o.valid && rsp_o.ready;
  assign load_out          = (state_q == StFinish) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.share_count = out_cnt_q;

  cnc_gcd #(
    .WIDTH (WIDTH)
  ) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (n_q),
    .b_i     (idx_q),
    .res_o   (gcd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      idx_q       <= '0;
      hi_q        <= '0;
      cnt_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      start_q <= 1'b0;
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_cnt_q   <= cnt_q;
      end else if (rsp_hs) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_hs) begin
            n_q   <= req_i.n_value;
            idx_q <= req_i.range_low;
            hi_q  <= req_i.range_high;
            cnt_q <= '0;
            if (req_i.n_value >= WIDTH'(MinShared) &&
                req_i.range_low <= req_i.range_high) begin
              start_q <= 1'b1;
              state_q <= StWait;
            end else begin
              state_q <= StFinish;
            end
          end
        end
        StWait: begin
          if (gcd_res.done) begin
            if (gcd_res.share) begin
              cnt_q <= cnt_q + (WIDTH+1)'(1);
            end
            if (idx_q == hi_q) begin
              state_q <= StFinish;
            end else begin
              // advance to the next range value
              idx_q   <= idx_q + WIDTH'(1);
              start_q <= 1'b1;
            end
          end
        end
        StFinish: begin
          // hold until the result register is free
          if (load_out) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cnc_pkg::*;

  typedef logic [CncWidth-1:0] operand_t;
  typedef logic [CncWidth:0]   count_t;

  localparam int unsigned MaxValue = (1 << CncWidth) - 1;

  // Holds the expected share counts in request order and checks results against them.
  class count_scoreboard;
    count_t      expected_q[$];
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_errors;

    function int unsigned gcd_of(int unsigned a, int unsigned b);
      int unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    function count_t count_shared_divisors(operand_t n, operand_t lo, operand_t hi);
      int unsigned total;
      total = 0;
      if (n >= MinShared && lo <= hi) begin
        // i is 32 bits wide, so the walk up to the top value cannot wrap
        for (int unsigned i = lo; i <= hi; i++) begin
          if (gcd_of(n, i) >= MinShared) total++;
        end
      end
      return count_t'(total);
    endfunction

    function void note_request(operand_t n, operand_t lo, operand_t hi);
      expected_q.push_back(count_shared_divisors(n, lo, hi));
      n_requests++;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      n_errors++;
    endtask

    task check_result(count_t got);
      count_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("share_count %0d with no request outstanding", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("share_count %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;

  count_scoreboard sb = new();

  cnc_req_if #(.WIDTH(CncWidth)) req_if ();
  cnc_rsp_if #(.WIDTH(CncWidth)) rsp_if ();

  count_non_coprime_in_range #(
    .WIDTH (CncWidth)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all in quiet stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(operand_t n, operand_t lo, operand_t hi);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.n_value    <= n;
    req_if.range_low  <= lo;
    req_if.range_high <= hi;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(n, lo, hi);
    @(negedge clk);
  endtask

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.share_count);
  end

  initial begin : stimulus
    operand_t    n;
    operand_t    lo;
    operand_t    hi;
    int unsigned pick;
    int unsigned span;
    int unsigned top;

    quiet             = 1'b1;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.n_value    = '0;
    req_if.range_low  = '0;
    req_if.range_high = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // small n, zero in range, empty range, top values, prime n, full range
    send_request(16'd0, 16'd0, 16'd10);
    send_request(16'd1, 16'd0, 16'd100);
    send_request(16'd1, 16'd0, 16'd0);
    send_request(16'd2, 16'd0, 16'd0);
    send_request(16'd12, 16'd20, 16'd10);
    send_request(16'd3, 16'hFFFF, 16'd0);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'hFFFF, 16'd65500, 16'hFFFF);
    send_request(16'd2, 16'd65534, 16'hFFFF);
    send_request(16'd65521, 16'd0, 16'd50);
    send_request(16'h8000, 16'd0, 16'd64);
    send_request(16'd6, 16'd1, 16'd1);
    send_request(16'hAAAA, 16'h5555, 16'h5560);
    send_request(16'd0, 16'd0, 16'hFFFF);
    send_request(16'd30030, 16'd0, 16'hFFFF);

    for (int k = 0; k < 100; k++) begin
      if (k % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0:       n = operand_t'($urandom_range(0, 3));
        1:       n = operand_t'(1 << $urandom_range(0, CncWidth - 1));
        2:       n = operand_t'($urandom_range(2, 300));
        default: n = operand_t'($urandom);
      endcase
      lo   = operand_t'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 1) lo = '0;
      if (pick == 0 && lo != 0) begin
        hi = lo - operand_t'($urandom_range(1, lo));
      end else begin
        span = (pick < 3) ? $urandom_range(41, 300) : $urandom_range(0, 40);
        top  = lo + span;
        hi   = (top > MaxValue) ? operand_t'(MaxValue) : operand_t'(top);
      end
      send_request(n, lo, hi);
    end
    req_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d requests and checked %0d results (%0d mismatches)",
             sb.n_requests, sb.n_results, sb.n_errors);
    $display("Covered small n, empty, top-end and full ranges, plus random spans and stalls");
    if (sb.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000_000;
    $display("Timed out with %0d results outstanding", sb.expected_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
